// ===== rtl/tvts_pkg.sv =====
// Package: widths, constants, sine table and helper functions for the tremolo sine synth.
`default_nettype none

package tvts_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 32;
	localparam int NUM_VOICES      = 3;
	localparam int VOICE_BITS      = 2;
	localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);
	localparam int MULT_BITS       = 17;
	localparam int LFO_PROD_BITS   = PHASE_BITS + MULT_BITS;
	localparam int PROD_BITS       = 32;
	localparam int ACC_BITS        = PROD_BITS + 2;
	localparam int GAIN_BITS       = 16;
	localparam int SCALED_BITS     = ACC_BITS + GAIN_BITS;
	localparam int ROUND_SHIFT     = 31;
	localparam int CFG_ADDR_BITS   = 2;

	localparam logic [CFG_ADDR_BITS-1:0] LFO_STEP_ADDR  = 2'd0;
	localparam logic [31:0]              LFO_STEP_RESET = 32'd48696;
	localparam logic signed [GAIN_BITS-1:0] MIX_GAIN    = 16'sd19661;
	localparam longint QONE = 64'sd1 << 20;

	typedef logic [PHASE_BITS-1:0]   phase_t;
	typedef logic [2*PHASE_BITS-1:0] phase_word_t;
	typedef logic [VOICE_BITS-1:0]   voice_t;
	typedef logic [14:0]             qsine_t [0:QUARTER];

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mix_ctl_t;

	// Quarter-wave magnitudes, odd polynomial of sin(pi/2*u) in Q20 fixed point.
	function automatic qsine_t build_qsine();
		qsine_t tab;
		longint u;
		longint u2;
		longint p;
		longint s;
		longint mag;
		for (int r = 0; r <= QUARTER; r++) begin
			u   = longint'(r) << (22 - SINE_TABLE_BITS);
			u2  = (u * u) / QONE;
			p   = 168;
			p   = -4909 + (p * u2) / QONE;
			p   = 83564 + (p * u2) / QONE;
			p   = -677344 + (p * u2) / QONE;
			p   = 1647099 + (p * u2) / QONE;
			s   = (p * u) / QONE;
			if (s < 0)
				s = 0;
			if (s > QONE)
				s = QONE;
			mag = (s * 32767 + (64'sd1 << 19)) >>> 20;
			if (mag > 32767)
				mag = 32767;
			tab[r] = mag[14:0];
		end
		return tab;
	endfunction

	localparam qsine_t QSINE = build_qsine();

	// Fold the phase into the quarter table, mirror and negate as the quadrant asks.
	function automatic logic signed [15:0] sine_lookup(phase_t ph);
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [SINE_TABLE_BITS-3:0] r;
		logic [SINE_TABLE_BITS-2:0] rr;
		logic [14:0]                mag;
		idx = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
		r   = idx[SINE_TABLE_BITS-3:0];
		if (idx[SINE_TABLE_BITS-2])
			rr = (SINE_TABLE_BITS-1)'(QUARTER) - {1'b0, r};
		else
			rr = {1'b0, r};
		mag = QSINE[rr];
		if (idx[SINE_TABLE_BITS-1])
			return 16'(-$signed({1'b0, mag}));
		else
			return $signed({1'b0, mag});
	endfunction

	// Zero-extend or truncate a 32-bit register value to the phase width.
	function automatic phase_t fit_phase(logic [31:0] v);
		phase_t o;
		for (int i = 0; i < PHASE_BITS; i++)
			o[i] = (i < 32) ? v[i % 32] : 1'b0;
		return o;
	endfunction

	// Voice pitch ratios 1, 1.5 and 2: floor(base * ratio), wrapped.
	function automatic phase_t tone_voice_step(phase_t base, voice_t k);
		phase_t o;
		unique case (k)
			2'd1:    o = base + (base >> 1);
			2'd2:    o = base << 1;
			default: o = base;
		endcase
		return o;
	endfunction

	// Tremolo ratios 1.00, 1.04 and 1.09 in Q16.
	function automatic logic [MULT_BITS-1:0] trem_mult(voice_t k);
		logic [MULT_BITS-1:0] m;
		unique case (k)
			2'd1:    m = 17'd68157;
			2'd2:    m = 17'd71434;
			default: m = 17'd65536;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/three_voice_tremolo_sine_synth_core.sv =====
// Top level: three-voice sine chord with per-voice sine tremolo, one sample per item.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  in      | into core | in_valid / in_stall  | load_tone, tone_word
//  out     | from core | out_valid / out_stall| sample (signed Q1.15)
//  cfg     | into core | APB psel/penable     | lfo_step at byte address 0
//
// From acceptance to the sample in the output register, the three voices walk
// one after another through the phase memory read port, then the sine lookup,
// product, accumulate and gain-scale stages. in_stall stays high until the
// sample is handed to the output register and drops as it is registered, so
// no item is accepted before the last one's sample is in the output register;
// the next item may be accepted while a finished sample still waits on out_stall.
// Reset clears the voice phases (through per-entry valid bits), the base step,
// and restores lfo_step to its default of 0.5 Hz at 44.1 kHz.
`default_nettype none

module three_voice_tremolo_sine_synth_core
	import tvts_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     load_tone,
	input  wire logic [31:0]              tone_word,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [15:0]            sample,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [CFG_ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]              pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// Phase memory: one word per voice, tone phase on top, tremolo phase below.
	phase_word_t phase_mem [0:NUM_VOICES-1];
	logic [NUM_VOICES-1:0] ph_valid_q;

	logic [31:0] lfo_step_q;
	phase_t      tone_step_q;
	logic        busy_q;
	logic        issue_q;
	voice_t      cnt_q;

	// Stage 1: read data lands, steps for the voice are ready.
	logic        vld_s1;
	voice_t      k_s1;
	phase_word_t rd_s1;
	logic        rd_ok_s1;
	phase_t      ts_s1;
	phase_t      ls_s1;

	// Stage 2: both sines looked up.
	mix_ctl_t           ctl_s2;
	logic signed [15:0] sin_tone_s2;
	logic signed [15:0] sin_trem_s2;

	// Stage 3: voice product.
	mix_ctl_t                    ctl_s3;
	logic signed [PROD_BITS-1:0] prod_s3;

	logic [LFO_PROD_BITS-1:0] lfo_prod;
	phase_t                   tone_ph;
	phase_t                   trem_ph;
	logic                     accept;
	logic                     cfg_wr;
	logic                     done;

	assign accept   = in_valid && !in_stall;
	assign in_stall = busy_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign prdata   = (paddr == LFO_STEP_ADDR) ? lfo_step_q : 32'd0;

	// Tremolo step for the voice being issued: lfo_step times its Q16 ratio.
	assign lfo_prod = LFO_PROD_BITS'(fit_phase(lfo_step_q)) * LFO_PROD_BITS'(trem_mult(cnt_q));

	// Entries never written read as zero phase.
	assign tone_ph = rd_ok_s1 ? rd_s1[2*PHASE_BITS-1:PHASE_BITS] : '0;
	assign trem_ph = rd_ok_s1 ? rd_s1[PHASE_BITS-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_step_q  <= LFO_STEP_RESET;
			tone_step_q <= '0;
			busy_q      <= 1'b0;
			issue_q     <= 1'b0;
			cnt_q       <= '0;
			ph_valid_q  <= '0;
			vld_s1      <= 1'b0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
		end else begin
			if (cfg_wr && paddr == LFO_STEP_ADDR)
				lfo_step_q <= pwdata;
			// Take the item: load the base step if load_tone is set, then issue the voices.
			if (accept) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				cnt_q   <= '0;
				if (load_tone)
					tone_step_q <= fit_phase(tone_word);
			end else begin
				if (done)
					busy_q <= 1'b0;
				if (issue_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == VOICE_BITS'(NUM_VOICES - 1))
						issue_q <= 1'b0;
				end
			end
			vld_s1 <= issue_q;
			if (vld_s1)
				ph_valid_q[k_s1] <= 1'b1;
			ctl_s2.vld   <= vld_s1;
			ctl_s2.first <= (k_s1 == '0);
			ctl_s2.last  <= (k_s1 == VOICE_BITS'(NUM_VOICES - 1));
			ctl_s3       <= ctl_s2;
		end
	end

	// Read port: registered, valid bit sampled alongside.
	always_ff @(posedge clk) begin
		if (issue_q) begin
			rd_s1    <= phase_mem[cnt_q];
			rd_ok_s1 <= ph_valid_q[cnt_q];
			k_s1     <= cnt_q;
			ts_s1    <= tone_voice_step(tone_step_q, cnt_q);
			ls_s1    <= lfo_prod[16 +: PHASE_BITS];
		end
	end

	// Write back the advanced phases; the next voice reads a different entry.
	always_ff @(posedge clk) begin
		if (vld_s1)
			phase_mem[k_s1] <= {tone_ph + ts_s1, trem_ph + ls_s1};
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			sin_tone_s2 <= sine_lookup(tone_ph);
			sin_trem_s2 <= sine_lookup(trem_ph);
		end
		if (ctl_s2.vld)
			prod_s3 <= PROD_BITS'(sin_tone_s2) * PROD_BITS'(sin_trem_s2);
	end

	tvts_mixer u_mixer (
		.clk       (clk),
		.arst_n    (arst_n),
		.prod_ctl  (ctl_s3),
		.prod      (prod_s3),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.sample    (sample),
		.done      (done)
	);

endmodule

`default_nettype wire

// ===== rtl/tvts_mixer.sv =====
// Mixer: accumulate the three voice products, scale by 0.3, round, saturate, hold the sample.
`default_nettype none

module tvts_mixer
	import tvts_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mix_ctl_t                      prod_ctl,
	input  wire logic signed [PROD_BITS-1:0]   prod,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic signed [15:0]                 sample,
	output logic                               done
);

	logic signed [ACC_BITS-1:0]    acc_q;
	logic                          sum_rdy_q;
	logic signed [SCALED_BITS-1:0] scaled_q;
	logic                          scaled_vld_q;
	logic                          out_valid_q;
	logic signed [15:0]            sample_q;
	logic signed [SCALED_BITS-1:0] rounded;
	logic signed [SCALED_BITS-ROUND_SHIFT-1:0] vshift;
	logic signed [15:0]            sat;

	// Round half up, then clamp to Q1.15.
	always_comb begin
		rounded = scaled_q + (SCALED_BITS'(1) <<< (ROUND_SHIFT - 1));
		vshift  = rounded[SCALED_BITS-1:ROUND_SHIFT];
		if (vshift > (SCALED_BITS-ROUND_SHIFT)'(32767))
			sat = 16'sh7FFF;
		else if (vshift < -(SCALED_BITS-ROUND_SHIFT)'(32768))
			sat = 16'sh8000;
		else
			sat = vshift[15:0];
	end

	assign done      = scaled_vld_q && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_rdy_q    <= 1'b0;
			scaled_vld_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			sum_rdy_q <= prod_ctl.vld && prod_ctl.last;
			if (sum_rdy_q)
				scaled_vld_q <= 1'b1;
			else if (done)
				scaled_vld_q <= 1'b0;
			if (done)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (prod_ctl.vld) begin
			if (prod_ctl.first)
				acc_q <= ACC_BITS'(prod);
			else
				acc_q <= acc_q + ACC_BITS'(prod);
		end
		if (sum_rdy_q)
			scaled_q <= SCALED_BITS'(acc_q) * SCALED_BITS'(MIX_GAIN);
		if (done)
			sample_q <= sat;
	end

endmodule

`default_nettype wire

// ===== rtl/tvts_checker.sv =====
// Port-level checker for the tremolo sine synth core, bound to the top level.
`default_nettype none

module tvts_checker
	import tvts_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_stall,
	input wire logic                     load_tone,
	input wire logic [31:0]              tone_word,
	input wire logic                     out_valid,
	input wire logic                     out_stall,
	input wire logic signed [15:0]       sample,
	input wire logic                     psel,
	input wire logic                     penable,
	input wire logic                     pwrite,
	input wire logic [CFG_ADDR_BITS-1:0] paddr,
	input wire logic [31:0]              pwdata,
	input wire logic [31:0]              prdata,
	input wire logic                     pready
);

	// Hold a stalled sample.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample))
		else $error("stalled sample dropped or changed");

	// One item at a time: after an accept the input side stalls.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// A new sample appears only when an item was in flight.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("sample without an item in flight");

	// The 0.3 gain keeps the mix off the negative rail.
	a_headroom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample != 16'sh8000)
		else $error("sample hit the negative rail");

endmodule

bind three_voice_tremolo_sine_synth_core tvts_checker u_tvts_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the three-voice tremolo sine synth core.
`timescale 1ns / 100ps

module tb_top;
	import tvts_pkg::*;

	// Bit-accurate tracker of the chord: voice and tremolo phases, base step,
	// LFO step, and the samples still owed by the core.
	class chord_tracker;
		phase_t               base_step;
		phase_t               lfo_step;
		phase_t               voice_ph [3];
		phase_t               trem_ph [3];
		int unsigned          tone_ratio [3];
		int unsigned          trem_ratio [3];
		logic signed [15:0]   owed_samples [$];
		int                   errors;

		function new();
			base_step  = '0;
			lfo_step   = LFO_STEP_RESET;
			tone_ratio = '{32'd65536, 32'd98304, 32'd131072};
			trem_ratio = '{32'd65536, 32'd68157, 32'd71434};
			for (int k = 0; k < 3; k++) begin
				voice_ph[k] = '0;
				trem_ph[k]  = '0;
			end
			errors = 0;
		endfunction

		// Q20 multiply, truncated toward zero.
		function longint q20_mul(longint a, longint b);
			return (a * b) / QONE;
		endfunction

		// Signed Q1.15 sine of a phase, from the quarter-wave polynomial.
		function longint sine_of(phase_t ph);
			int unsigned idx;
			int unsigned quad;
			longint      r;
			longint      u;
			longint      u2;
			longint      p;
			longint      s;
			longint      mag;
			idx  = ph >> (PHASE_BITS - SINE_TABLE_BITS);
			quad = (idx >> (SINE_TABLE_BITS - 2)) & 3;
			r    = idx & (QUARTER - 1);
			if (quad & 1)
				r = QUARTER - r;
			u  = r << (22 - SINE_TABLE_BITS);
			u2 = q20_mul(u, u);
			p  = 168;
			p  = -4909 + q20_mul(p, u2);
			p  = 83564 + q20_mul(p, u2);
			p  = -677344 + q20_mul(p, u2);
			p  = 1647099 + q20_mul(p, u2);
			s  = q20_mul(p, u);
			if (s < 0)
				s = 0;
			if (s > QONE)
				s = QONE;
			mag = (s * 32767 + (64'sd1 << 19)) >>> 20;
			if (mag > 32767)
				mag = 32767;
			return (quad & 2) ? -mag : mag;
		endfunction

		function void set_lfo(logic [31:0] v);
			lfo_step = v;
		endfunction

		// Work out the sample for one accepted item, then advance all phases.
		function void take_item(bit load, logic [31:0] word);
			longint             mix;
			longint             v;
			logic [63:0]        step;
			logic signed [15:0] s16;
			if (load)
				base_step = word;
			mix = 0;
			for (int k = 0; k < 3; k++)
				mix += sine_of(voice_ph[k]) * sine_of(trem_ph[k]);
			v = (mix * longint'(MIX_GAIN) + (64'sd1 << 30)) >>> 31;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			s16 = v[15:0];
			owed_samples.insert(owed_samples.size(), s16);
			for (int k = 0; k < 3; k++) begin
				step        = (64'(base_step) * 64'(tone_ratio[k])) >> 16;
				voice_ph[k] = voice_ph[k] + step[PHASE_BITS-1:0];
				step        = (64'(lfo_step) * 64'(trem_ratio[k])) >> 16;
				trem_ph[k]  = trem_ph[k] + step[PHASE_BITS-1:0];
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= 200)
				$display("MISMATCH: %s", what);
		endtask

		task match_sample(logic signed [15:0] got);
			logic signed [15:0] want;
			if (owed_samples.size() == 0) begin
				report($sformatf("sample %0d arrived with no item pending", got));
			end else begin
				want = owed_samples.pop_front();
				if (got !== want)
					report($sformatf("sample got %0d, want %0d", got, want));
			end
		endtask
	endclass

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 12;
	localparam int PHASE_ITEMS = 180;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     load_tone;
	logic [31:0]              tone_word;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [15:0]       sample;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [31:0]              pwdata;
	logic [31:0]              prdata;
	logic                     pready;

	chord_tracker chord = new();

	bit  no_idle;      // both sides run flat out while set
	int  burst_left;   // sender items still to offer with no gap
	bit  hold_req;     // ask the receiver for one long hold-off
	int  cycles;

	three_voice_tremolo_sine_synth_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.load_tone (load_tone),
		.tone_word (tone_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Bound the run; a hung handshake ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("three_voice_tremolo_sine_synth_core regression: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	// Sample every accepted output item against the oldest owed sample.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			chord.match_sample(sample);
	end

	// Receiver: draw a stall after each accepted item; honor one long hold-off.
	initial begin
		int gap;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				hold_req  <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (out_valid && !out_stall) begin
				gap = pick_gap();
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Offer one item after a random gap, hold it until accepted, then predict.
	task automatic send_item(input bit load, input logic [31:0] word);
		int gap;
		gap = (burst_left > 0) ? 0 : pick_gap();
		if (burst_left > 0)
			burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		load_tone <= load;
		tone_word <= word;
		do @(posedge clk); while (in_stall);
		chord.take_item(load, word);
	endtask

	// Wait until every owed sample has come back.
	task automatic drain();
		while (chord.owed_samples.size() != 0)
			@(posedge clk);
	endtask

	// Write lfo_step through the setup and access cycles, then read it back.
	task automatic write_lfo(input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LFO_STEP_ADDR;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		chord.set_lfo(v);
		// Turn straight into the read setup; psel stays high.
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== v)
			chord.report($sformatf("lfo_step read %h, wrote %h", prdata, v));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Let the core go idle before touching its register.
	task automatic settle_and_write(input logic [31:0] v);
		in_valid <= 1'b0;
		drain();
		repeat (SETTLE) @(posedge clk);
		write_lfo(v);
	endtask

	// Mix of full-range, audio-range and coarse sixteenth-turn-aligned steps.
	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 32'h000F_FFFF);
			1:       return {4'($urandom_range(0, 15)), 28'h0};
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] lfo_val;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		load_tone  = 1'b0;
		tone_word  = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		no_idle    = 1'b0;
		burst_left = 0;
		hold_req   = 1'b0;
		cycles     = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a few items at the reset LFO step, including a word that
		// must be ignored because load_tone is low.
		send_item(1'b0, 32'hFFFF_FFFF);
		send_item(1'b1, 32'h0000_0000);
		send_item(1'b1, 32'h4000_0000);

		// Quarter-turn tremolo so the products are large from the start.
		settle_and_write(32'h4000_0000);
		send_item(1'b0, 32'h0000_0000);
		send_item(1'b0, 32'h0000_0000);
		send_item(1'b0, 32'h0000_0000);
		// Max step: the 1.5x and 2x voice steps wrap.
		send_item(1'b1, 32'hFFFF_FFFF);
		send_item(1'b0, 32'h1234_5678);
		send_item(1'b0, 32'hFFFF_FFFF);
		// Half-turn step; the 2x voice step wraps to zero.
		send_item(1'b1, 32'h8000_0000);
		send_item(1'b0, 32'h8000_0000);
		// One table entry per sample, then the minimum step.
		send_item(1'b1, 32'h0040_0000);
		send_item(1'b0, 32'h0040_0000);
		send_item(1'b1, 32'h0000_0001);
		send_item(1'b1, 32'hAAAA_AAAA);
		send_item(1'b1, 32'h5555_5555);
		send_item(1'b1, 32'h4000_0000);
		send_item(1'b0, 32'h0000_0000);
		send_item(1'b0, 32'h0000_0000);
		send_item(1'b1, 32'hC000_0000);
		send_item(1'b0, 32'h0000_0000);

		// Random phases, each under its own LFO step.
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0:       lfo_val = 32'h0000_0000;
				1:       lfo_val = 32'hFFFF_FFFF;
				3:       lfo_val = 32'h8000_0000;
				4:       lfo_val = $urandom_range(1, 32'h00FF_FFFF);
				8:       lfo_val = 32'h0000_0001;
				9:       lfo_val = LFO_STEP_RESET;
				default: lfo_val = $urandom;
			endcase
			settle_and_write(lfo_val);
			no_idle = (ph == 2);
			if (ph == 4) begin
				// Stall the output for a long stretch and keep feeding.
				hold_req   <= 1'b1;
				burst_left = 40;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 6 && i == PHASE_ITEMS / 2) begin
					// Pause the sender until every owed sample is out.
					in_valid <= 1'b0;
					drain();
				end
				send_item(($urandom_range(0, 7) == 0), random_word());
			end
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		drain();
		repeat (SETTLE) @(posedge clk);
		if (chord.errors == 0 && chord.owed_samples.size() == 0)
			$display("three_voice_tremolo_sine_synth_core regression: pass");
		else
			$display("three_voice_tremolo_sine_synth_core regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tvts_pkg.sv
rtl/tvts_mixer.sv
rtl/three_voice_tremolo_sine_synth_core.sv
rtl/tvts_checker.sv
bench/tb_top.sv
